### hdl/stksort_pkg.sv
// ----------------------------------------------------------------------------
// stksort_pkg
// Shared sizes, opcodes and item types of the sorting stack.
// ----------------------------------------------------------------------------
package stksort_pkg;

	// store geometry
	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// opcodes
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;
	localparam logic [1:0] OP_SORT = 2'd3;

	// request item
	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] push_value;
	} stksort_in_t;

	// result item
	typedef struct packed {
		logic signed [31:0] read_value;
		logic               was_empty;
		logic               rejected;
		logic [6:0]         entry_count;
	} stksort_out_t;

endpackage

### hdl/stksort_ram.sv
// ----------------------------------------------------------------------------
// stksort_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module stksort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/stack_with_in_place_sort_top.sv
// ----------------------------------------------------------------------------
// stack_with_in_place_sort_top
// Stack of signed values with push, pop, peek and in-place selection sort.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready/in_item, one result per request leaves
//   on out_valid/out_ready/out_item. Each item carries an opcode (push, pop,
//   peek, sort) and a push value; each result carries the read value, empty
//   and rejected flags and the entry count after the operation.
//   Push, and pop/peek on an empty stack, finish in the accept cycle: the
//   result is loaded into the output register at the end of that cycle,
//   and such items can be taken once per cycle while the receiver keeps up.
//   Pop and peek on a non-empty stack pass through S_READ for the store's
//   registered read.
//   Sort holds the request side while one compare unit walks the store, one
//   entry read per cycle, and each pass ends with at most two writes for the
//   swap, in S_SWAP1 and S_SWAP2.
//   Only one item is in flight at a time; a new item is taken when the output
//   register is empty or is being emptied in the same cycle, so a stalled
//   receiver stalls the request side.
//   Reset empties the stack; store contents are not cleared and need no
//   clearing pass.
// ----------------------------------------------------------------------------
module stack_with_in_place_sort_top
	import stksort_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  stksort_in_t  in_item,
	output logic         out_valid,
	input  logic         out_ready,
	output stksort_out_t out_item
);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_ISSUE = 3'd2;
	localparam logic [2:0] S_FIRST = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_SWAP1 = 3'd5;
	localparam logic [2:0] S_SWAP2 = 3'd6;

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      pass_q;
	logic [IDX_W-1:0]      rd_ptr_q;
	logic [IDX_W-1:0]      cmp_idx_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [DATA_WIDTH-1:0] best_val_q;
	logic [DATA_WIDTH-1:0] first_val_q;
	logic                  out_valid_q;
	stksort_out_t          out_q;

	logic                  in_fire;
	logic                  full;
	logic                  empty;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [IDX_W-1:0]      ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;
	logic                  take_new;
	logic                  scan_last;
	logic                  more_passes;
	logic [IDX_W-1:0]      pass_nxt;
	logic                  res_load;
	stksort_out_t          res_d;

	assign full        = (count_q == CNT_W'(DEPTH));
	assign empty       = (count_q == '0);
	assign in_ready    = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_fire     = in_valid && in_ready;
	assign take_new    = $signed(ram_rdata) < $signed(best_val_q);
	assign scan_last   = (CNT_W'(cmp_idx_q) == count_q - 1'b1);
	assign pass_nxt    = pass_q + 1'b1;
	assign more_passes = (CNT_W'(pass_q) + CNT_W'(2) < count_q);

	// read address: top of stack while idle, scan pointer while sorting
	assign ram_raddr = (state_q == S_IDLE) ? IDX_W'(count_q - 1'b1) : rd_ptr_q;

	// write port: push, or the two halves of a swap
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(count_q);
		ram_wdata = DATA_WIDTH'(in_item.push_value);
		case (state_q)
			S_IDLE: begin
				ram_we = in_fire && (in_item.opcode == OP_PUSH) && !full;
			end
			S_SWAP1: begin
				ram_we    = (best_idx_q != pass_q);
				ram_waddr = pass_q;
				ram_wdata = best_val_q;
			end
			S_SWAP2: begin
				ram_we    = 1'b1;
				ram_waddr = best_idx_q;
				ram_wdata = first_val_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// result assembly
	always_comb begin
		res_load             = 1'b0;
		res_d.read_value     = '0;
		res_d.was_empty      = 1'b0;
		res_d.rejected       = 1'b0;
		res_d.entry_count    = 7'(count_q);
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					case (in_item.opcode)
						OP_PUSH: begin
							res_load          = 1'b1;
							res_d.rejected    = full;
							res_d.entry_count = full ? 7'(count_q) : 7'(count_q + 1'b1);
						end
						OP_POP, OP_PEEK: begin
							res_load        = empty;
							res_d.was_empty = 1'b1;
						end
						default: begin
							res_load = (count_q < CNT_W'(2));
						end
					endcase
				end
			end
			S_READ: begin
				res_load         = 1'b1;
				res_d.read_value = 32'($signed(ram_rdata));
			end
			S_SWAP1: begin
				res_load = (best_idx_q == pass_q) && !more_passes;
			end
			S_SWAP2: begin
				res_load = !more_passes;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// sequencer and stack depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pass_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						case (in_item.opcode)
							OP_PUSH: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
							end
							OP_POP, OP_PEEK: begin
								if (!empty) begin
									state_q <= S_READ;
									if (in_item.opcode == OP_POP) begin
										count_q <= count_q - 1'b1;
									end
								end
							end
							default: begin
								if (!(count_q < CNT_W'(2))) begin
									state_q <= S_ISSUE;
									pass_q  <= '0;
								end
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				S_ISSUE: begin
					state_q <= S_FIRST;
				end
				S_FIRST: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_last) begin
						state_q <= S_SWAP1;
					end
				end
				S_SWAP1: begin
					if (best_idx_q != pass_q) begin
						state_q <= S_SWAP2;
					end else if (more_passes) begin
						state_q <= S_ISSUE;
						pass_q  <= pass_nxt;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SWAP2: begin
					if (more_passes) begin
						state_q <= S_ISSUE;
						pass_q  <= pass_nxt;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// scan pointers and the running minimum of a pass
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				rd_ptr_q <= '0;
			end
			S_ISSUE: begin
				rd_ptr_q <= pass_q + 1'b1;
			end
			S_FIRST: begin
				best_val_q  <= ram_rdata;
				first_val_q <= ram_rdata;
				best_idx_q  <= pass_q;
				cmp_idx_q   <= rd_ptr_q;
				rd_ptr_q    <= rd_ptr_q + 1'b1;
			end
			S_SCAN: begin
				if (take_new) begin
					best_val_q <= ram_rdata;
					best_idx_q <= cmp_idx_q;
				end
				cmp_idx_q <= rd_ptr_q;
				rd_ptr_q  <= rd_ptr_q + 1'b1;
			end
			default: begin
				rd_ptr_q <= pass_nxt;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// value store
	stksort_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("stack depth beyond capacity");

	a_busy_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !out_valid_q)
		else $error("result register occupied while an item is in work");

	a_busy_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(count_q))
		else $error("depth changed during a multi-cycle operation");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (in_item.opcode == OP_PUSH) && !full)
			|=> (count_q == CNT_W'($past(count_q) + 1'b1)))
		else $error("accepted push did not grow the stack");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorting stack.
// A queue of request items (a short directed opening, then random bursts
// that fill, drain and mix operations) feeds a valid/ready driver. A local
// stack model predicts each result as the item is taken. A monitor with
// random backpressure checks every result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb
	import stksort_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// burst kinds for the random part
	typedef enum int {
		BURST_FILL,
		BURST_DRAIN,
		BURST_MIX
	} burst_e;

	localparam int RAND_ITEMS = 1400;
	localparam int HOLD_LEN   = 300;
	localparam int HOLD_EVERY = 25000;
	localparam int HOLD_AT    = 1500;
	localparam int TAIL_WAIT  = 50;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         in_valid = 1'b0;
	logic         in_ready;
	stksort_in_t  in_item = '0;
	logic         out_valid;
	logic         out_ready = 1'b0;
	stksort_out_t out_item;

	stack_with_in_place_sort_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// pending requests and predicted results
	stksort_in_t  pend_q[$];
	stksort_out_t want_q[$];

	// stack model state
	logic signed [DATA_WIDTH-1:0] stack_mem [DEPTH];
	int held_n = 0;

	// generator bookkeeping
	int est_depth = 0;
	int est_cycles = 0;
	int cyc_limit = 0;
	int cyc = 0;

	// run statistics
	int n_push = 0, n_refused = 0, n_read = 0, n_empty_read = 0;
	int n_sort = 0, n_deep_sort = 0, max_held = 0;
	int n_results = 0, fail_cnt = 0;

	// handshake pacing
	int  send_wait = 0;
	int  recv_wait = 0;
	int  hold_left = 0;
	bit  calm_in = 1'b0;
	bit  calm_out = 1'b0;

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// stack model: apply one request, return the result it produces
	function automatic stksort_out_t step_stack(stksort_in_t req);
		stksort_out_t res;
		logic signed [DATA_WIDTH-1:0] tmp;
		int best;
		res = '0;
		case (req.opcode)
			OP_PUSH: begin
				n_push++;
				if (held_n >= DEPTH) begin
					res.rejected = 1'b1;
					n_refused++;
				end else begin
					stack_mem[held_n] = req.push_value;
					held_n++;
				end
			end
			OP_POP, OP_PEEK: begin
				n_read++;
				if (held_n == 0) begin
					res.was_empty = 1'b1;
					n_empty_read++;
				end else begin
					res.read_value = stack_mem[held_n - 1];
					if (req.opcode == OP_POP)
						held_n--;
				end
			end
			default: begin
				// selection sort, smallest to the bottom, first minimum wins
				n_sort++;
				if (held_n >= 48)
					n_deep_sort++;
				for (int lo = 0; lo + 1 < held_n; lo++) begin
					best = lo;
					for (int j = lo + 1; j < held_n; j++) begin
						if (stack_mem[j] < stack_mem[best])
							best = j;
					end
					if (best != lo) begin
						tmp = stack_mem[lo];
						stack_mem[lo] = stack_mem[best];
						stack_mem[best] = tmp;
					end
				end
			end
		endcase
		if (held_n > max_held)
			max_held = held_n;
		res.entry_count = 7'(held_n);
		return res;
	endfunction

	// push a request onto the stimulus queue and track rough depth and cost
	function automatic void queue_item(logic [1:0] op, logic signed [31:0] val);
		stksort_in_t it;
		it.opcode = op;
		it.push_value = val;
		pend_q.push_back(it);
		est_cycles += 12;
		case (op)
			OP_PUSH: if (est_depth < DEPTH) est_depth++;
			OP_POP:  if (est_depth > 0) est_depth--;
			OP_SORT: est_cycles += est_depth * est_depth / 2 + 4 * est_depth + 8;
			default: ;
		endcase
	endfunction

	// push values: mostly random, some clustered for duplicates, some extremes
	function automatic logic signed [31:0] rand_value();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			5, 6:    return 32'($urandom_range(0, 16)) - 32'sd8;
			7:       return 32'sh8000_0000 + 32'($urandom_range(0, 2));
			8:       return 32'sh7fff_ffff - 32'($urandom_range(0, 2));
			default: return $urandom;
		endcase
	endfunction

	// stimulus, reset and end of run
	initial begin : stim
		burst_e kind;
		int n_rand, len, r;
		logic [1:0] op;

		// directed opening: empty cases, extremes, duplicates, sorts
		queue_item(OP_PEEK, $urandom);
		queue_item(OP_POP, $urandom);
		queue_item(OP_SORT, $urandom);
		queue_item(OP_PUSH, 32'sh8000_0000);
		queue_item(OP_SORT, $urandom);
		queue_item(OP_PEEK, $urandom);
		queue_item(OP_PUSH, 32'sh7fff_ffff);
		queue_item(OP_PUSH, 32'sd0);
		queue_item(OP_PUSH, -32'sd1);
		queue_item(OP_PUSH, 32'sd1);
		queue_item(OP_PUSH, 32'sd5);
		queue_item(OP_PUSH, 32'sd5);
		queue_item(OP_PUSH, 32'sh8000_0000);
		queue_item(OP_PUSH, 32'sh5555_5555);
		queue_item(OP_PUSH, 32'shaaaa_aaaa);
		queue_item(OP_SORT, $urandom);
		queue_item(OP_PEEK, $urandom);
		for (int k = 0; k < 5; k++)
			queue_item(OP_POP, $urandom);
		queue_item(OP_SORT, $urandom);
		queue_item(OP_PEEK, $urandom);

		// random bursts
		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			r = $urandom_range(0, 9);
			kind = (r < 2) ? BURST_FILL : (r < 4) ? BURST_DRAIN : BURST_MIX;
			case (kind)
				BURST_FILL: begin
					// run up to full and at times past it, sometimes sort the full stack
					len = DEPTH - est_depth + $urandom_range(0, 4);
					for (int k = 0; k < len; k++)
						queue_item(OP_PUSH, rand_value());
					if ($urandom_range(0, 2) == 0) begin
						queue_item(OP_SORT, $urandom);
						len++;
					end
				end
				BURST_DRAIN: begin
					// pop, with an occasional peek, as many items as are held plus up to three more
					len = est_depth + $urandom_range(0, 3);
					for (int k = 0; k < len; k++)
						queue_item(($urandom_range(0, 7) == 0) ? OP_PEEK : OP_POP,
							$urandom);
				end
				default: begin
					len = $urandom_range(10, 40);
					for (int k = 0; k < len; k++) begin
						r = $urandom_range(0, 99);
						op = (r < 40) ? OP_PUSH : (r < 70) ? OP_POP :
							(r < 94) ? OP_PEEK : OP_SORT;
						queue_item(op, (op == OP_PUSH) ? rand_value() : $urandom);
					end
				end
			endcase
			n_rand += len;
		end
		cyc_limit = 4 * est_cycles + 20000
			+ 4 * HOLD_LEN * (est_cycles / HOLD_EVERY + 2);

		// reset once
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: all items taken and every result back
		while (pend_q.size() != 0 || in_valid || want_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_WAIT) @(negedge clk);

		$display("ran %0d results: %0d pushes (%0d refused at full)",
			n_results, n_push, n_refused);
		$display("%0d pops/peeks (%0d on empty), %0d sorts (%0d at depth 48 or more)",
			n_read, n_empty_read, n_sort, n_deep_sort);
		$display("deepest fill %0d of %0d, %0d failures", max_held, DEPTH, fail_cnt);
		if (fail_cnt == 0 && want_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc_limit != 0 && cyc >= cyc_limit) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cyc, want_q.size());
			$display("status: fail");
			$finish;
		end
	end

	// driver: offer queued items, predict each one as it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				want_q.push_back(step_stack(in_item));
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					send_wait <= send_wait - 1;
					in_valid <= 1'b0;
				end else if (pend_q.size() != 0) begin
					in_item <= pend_q.pop_front();
					in_valid <= 1'b1;
					send_wait <= calm_in ? 0 : $urandom_range(0, 4);
				end else begin
					in_valid <= 1'b0;
				end
			end
			if ($urandom_range(0, 39) == 0)
				calm_in <= !calm_in;
		end
	end

	// long receiver hold-off so the block backs up into its input
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0)
				hold_left <= hold_left - 1;
			else if (cyc % HOLD_EVERY == HOLD_AT)
				hold_left <= HOLD_LEN;
		end
	end

	// monitor: check each result item, then pace out_ready
	always @(posedge clk) begin : mon
		stksort_out_t want;
		int w;
		if (arst_n) begin
			w = recv_wait;
			if (out_valid && out_ready) begin
				n_results++;
				if (want_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("unexpected result item: value %0d empty %0b rej %0b count %0d",
							out_item.read_value, out_item.was_empty,
							out_item.rejected, out_item.entry_count);
				end else begin
					want = want_q.pop_front();
					if (out_item.read_value !== want.read_value ||
						out_item.was_empty !== want.was_empty ||
						out_item.rejected !== want.rejected ||
						out_item.entry_count !== want.entry_count) begin
						fail_cnt++;
						if (fail_cnt <= 10) begin
							$display("result %0d mismatch: exp value %0d empty %0b rej %0b count %0d",
								n_results, want.read_value, want.was_empty,
								want.rejected, want.entry_count);
							$display("  got value %0d empty %0b rej %0b count %0d",
								out_item.read_value, out_item.was_empty,
								out_item.rejected, out_item.entry_count);
						end
					end
				end
				w = calm_out ? 0 : $urandom_range(0, 4);
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (w > 0) begin
				out_ready <= 1'b0;
				w = w - 1;
			end else begin
				out_ready <= 1'b1;
			end
			recv_wait <= w;
			if ($urandom_range(0, 39) == 0)
				calm_out <= !calm_out;
		end
	end

endmodule

### filelist.f
hdl/stksort_pkg.sv
hdl/stksort_ram.sv
hdl/stack_with_in_place_sort_top.sv
verif/tb.sv
